FILE: hw/rtl/min_max_gray_stretch_top_assert.svh
// Assertion helpers for the min/max stretch block, clocked on clk, quiet in reset.
`ifndef MIN_MAX_GRAY_STRETCH_TOP_ASSERT_SVH
`define MIN_MAX_GRAY_STRETCH_TOP_ASSERT_SVH

// same-cycle implication
`define MMGS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MMGS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/mmgs_pkg.sv
`default_nettype none
package mmgs_pkg;

	localparam int PIX_BITS   = 16;
	localparam int GRAY_BITS  = 8;
	localparam int IN_BITS_DEF = 16;
	localparam logic [GRAY_BITS-1:0] GRAY_MAX  = '1;
	localparam logic [GRAY_BITS-1:0] GRAY_ZERO = '0;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mmgs_in_if.sv
`default_nettype none
interface mmgs_in_if;
	import mmgs_pkg::*;

	logic                valid;
	logic                ready;
	logic                func;
	logic                frame_start;
	logic [PIX_BITS-1:0] pixel_value;

	modport source(output valid, output func, output frame_start, output pixel_value,
		input ready);
	modport sink(input valid, input func, input frame_start, input pixel_value,
		output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mmgs_out_if.sv
`default_nettype none
interface mmgs_out_if;
	import mmgs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [GRAY_BITS-1:0] gray_value;

	modport source(output valid, output gray_value, input ready);
	modport sink(input valid, input gray_value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mmgs_div.sv
`default_nettype none
module mmgs_div #(
	parameter int W = mmgs_pkg::IN_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [W+mmgs_pkg::GRAY_BITS-1:0]      num,
	input  logic [W-1:0]                          span,
	output logic [mmgs_pkg::GRAY_BITS-1:0]        quot,
	output mmgs_pkg::div_stat_t                   stat
);
	import mmgs_pkg::*;

	localparam int NW    = W + GRAY_BITS;
	localparam int BIT_W = $clog2(GRAY_BITS);

	logic [NW-1:0]        rem_q;
	logic [W-1:0]         span_q;
	logic [GRAY_BITS-1:0] quot_q;
	logic [BIT_W-1:0]     bit_q;
	logic                 busy_q;
	logic                 done_q;
	logic [NW-1:0]        trial;
	logic                 fits;

	// divisor lined up under the current quotient bit
	assign trial = {{GRAY_BITS{1'b0}}, span_q} << bit_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			bit_q  <= BIT_W'(GRAY_BITS - 1);
		end else if (busy_q) begin
			if (bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				bit_q <= bit_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			span_q <= span;
			quot_q <= '0;
		end else if (busy_q && fits) begin
			rem_q         <= rem_q - trial;
			quot_q[bit_q] <= 1'b1;
		end
	end

	assign quot      = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire

FILE: hw/rtl/min_max_gray_stretch_top.sv
// Min/max contrast stretch of a grey frame to 8 bits. Stream the frame once with func 0 to
// measure it (frame_start on the first pixel restarts the minimum and maximum), then again
// with func 1 to get one gray_value per pixel, floor((p-min)*255/(max-min)), saturating to 0
// at or below the minimum and to 255 at or above the maximum; a flat or unmeasured range
// gives 0. Measure items give no result. Map items whose pixel lies outside the open range
// go straight to the output register. Others pass through accept, a setup state that forms
// (p-min)*255 and max-min, eight steps of the restoring divider (one quotient bit each),
// and the load of the output register; input ready stays low meanwhile.
// Any item also waits while a result sits unaccepted in the output register.
`default_nettype none
`include "min_max_gray_stretch_top_assert.svh"
module min_max_gray_stretch_top #(
	parameter int IN_BITS = mmgs_pkg::IN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	mmgs_in_if.sink           pix_in,
	mmgs_out_if.source        gray_out
);
	import mmgs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [1:0]                   state_q;
	logic [IN_BITS-1:0]           low_q;
	logic [IN_BITS-1:0]           high_q;
	logic [IN_BITS-1:0]           pix_q;
	logic [IN_BITS-1:0]           pix;
	logic                         out_valid_q;
	logic [GRAY_BITS-1:0]         gray_q;
	logic                         out_free;
	logic                         in_acc;
	logic                         meas_acc;
	logic                         map_acc;
	logic                         flat;
	logic                         below;
	logic                         above;
	logic                         direct;
	logic [IN_BITS-1:0]           diff;
	logic [IN_BITS-1:0]           span;
	logic [IN_BITS+GRAY_BITS-1:0] num;
	logic                         div_start;
	logic                         div_load;
	logic [GRAY_BITS-1:0]         quot;
	div_stat_t                    div_stat;

	assign out_free     = !out_valid_q || gray_out.ready;
	assign pix_in.ready = (state_q == S_IDLE) && out_free;
	assign in_acc       = pix_in.valid && pix_in.ready;
	assign meas_acc     = in_acc && !pix_in.func;
	assign map_acc      = in_acc && pix_in.func;
	assign pix          = pix_in.pixel_value[IN_BITS-1:0];

	assign flat   = high_q <= low_q;
	assign below  = pix <= low_q;
	assign above  = pix >= high_q;
	assign direct = flat || below || above;

	// (p - min) * (2^GRAY_BITS - 1) as a shift and subtract
	assign diff      = pix_q - low_q;
	assign span      = high_q - low_q;
	assign num       = {diff, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{1'b0}}, diff};
	assign div_start = state_q == S_PREP;
	assign div_load  = (state_q == S_DIV) && div_stat.done && out_free;

	mmgs_div #(.W(IN_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.span   (span),
		.quot   (quot),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (map_acc && !direct)
						state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '1;
			high_q <= '0;
		end else if (meas_acc) begin
			if (pix_in.frame_start) begin
				low_q  <= pix;
				high_q <= pix;
			end else begin
				if (pix > high_q)
					high_q <= pix;
				if (pix < low_q)
					low_q <= pix;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (map_acc)
			pix_q <= pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((map_acc && direct) || div_load) begin
			out_valid_q <= 1'b1;
		end else if (gray_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (map_acc && direct)
			gray_q <= (flat || below) ? GRAY_ZERO : GRAY_MAX;
		else if (div_load)
			gray_q <= quot;
	end

	assign gray_out.valid      = out_valid_q;
	assign gray_out.gray_value = gray_q;

	`MMGS_ASSERT_IMP(a_div_owned, div_stat.busy, state_q == S_DIV, "divider busy outside S_DIV")
	`MMGS_ASSERT_NXT(a_range_ordered, meas_acc, low_q <= high_q, "minimum above maximum")
	`MMGS_ASSERT_NXT(a_div_out, div_load, out_valid_q && gray_q == $past(quot), "quotient lost")
	`MMGS_ASSERT_IMP(a_no_take_busy, state_q != S_IDLE, !in_acc, "item taken during division")
endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import mmgs_pkg::*;

	localparam int IN_BITS = IN_BITS_DEF;
	localparam logic [PIX_BITS-1:0] PIX_MASK = PIX_BITS'((1 << IN_BITS) - 1);
	localparam logic FUNC_MEASURE = 1'b0;
	localparam logic FUNC_MAP     = 1'b1;
	localparam int RANDOM_ITEMS = 1800;
	localparam int STALL_LONG   = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic                func;
		logic                start;
		logic [PIX_BITS-1:0] pix;
	} pix_item_t;

	typedef enum {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_pattern_t;
	typedef enum {FRAME_NOISE, FRAME_FLAT, FRAME_NARROW, FRAME_WIDE} frame_kind_t;

	class stretch_checker;
		logic [PIX_BITS-1:0]  min_seen;
		logic [PIX_BITS-1:0]  max_seen;
		logic [GRAY_BITS-1:0] gray_due[$];
		int                   mismatches;

		function new();
			min_seen   = PIX_MASK;
			max_seen   = '0;
			mismatches = 0;
		endfunction

		function logic [GRAY_BITS-1:0] stretch_level(logic [PIX_BITS-1:0] pix);
			int unsigned span;
			int unsigned offset;
			if (max_seen <= min_seen) return GRAY_ZERO;
			if (pix <= min_seen) return GRAY_ZERO;
			if (pix >= max_seen) return GRAY_MAX;
			span   = max_seen - min_seen;
			offset = pix - min_seen;
			return GRAY_BITS'((offset * GRAY_MAX) / span);
		endfunction

		function void note_pixel(pix_item_t it);
			logic [PIX_BITS-1:0] pix;
			pix = it.pix & PIX_MASK;
			if (it.func == FUNC_MEASURE) begin
				if (it.start) begin
					min_seen = pix;
					max_seen = pix;
				end else begin
					if (pix > max_seen) max_seen = pix;
					if (pix < min_seen) min_seen = pix;
				end
			end else begin
				gray_due.push_back(stretch_level(pix));
			end
		endfunction

		function void check_gray(logic [GRAY_BITS-1:0] got);
			logic [GRAY_BITS-1:0] want;
			if (gray_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("gray_value %0d arrived with no map item pending", got);
				return;
			end
			want = gray_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("gray_value mismatch: expected %0d, actual %0d", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	mmgs_in_if  pix_in();
	mmgs_out_if gray_out();

	stretch_checker stretch_chk;
	int  items_sent;
	int  burst_left;
	bit  gaps_on;
	int  hold_asks;
	int  cycle_count;

	min_max_gray_stretch_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.gray_out (gray_out)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result checked before the input of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (gray_out.valid && gray_out.ready)
				stretch_chk.check_gray(gray_out.gray_value);
			if (pix_in.valid && pix_in.ready)
				stretch_chk.note_pixel('{pix_in.func, pix_in.frame_start, pix_in.pixel_value});
		end
	end

	// receiver: own stall pattern, plus a long hold-off whenever one is asked for
	initial begin
		int          seg_left;
		int          holds_done;
		rx_pattern_t pattern;
		seg_left   = 0;
		holds_done = 0;
		pattern    = RX_OPEN;
		gray_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != holds_done) begin
				gray_out.ready <= 1'b0;
				repeat (STALL_LONG - 1) @(posedge clk);
				holds_done++;
			end else begin
				if (seg_left == 0) begin
					pattern  = rx_pattern_t'($urandom_range(2, 0));
					seg_left = $urandom_range(40, 4);
				end
				seg_left--;
				case (pattern)
					RX_OPEN:   gray_out.ready <= 1'b1;
					RX_CHOPPY: gray_out.ready <= 1'($urandom_range(1, 0));
					default:   gray_out.ready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

	task automatic send_pixel(pix_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(6, 1) : 0;
			if (gap != 0) begin
				pix_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(16, 1);
		end
		burst_left--;
		pix_in.valid       <= 1'b1;
		pix_in.func        <= it.func;
		pix_in.frame_start <= it.start;
		pix_in.pixel_value <= it.pix;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		items_sent++;
	endtask

	// one frame: measure pass then map pass, with the odd broken or noisy frame or skipped measure pass
	task automatic run_frame(bit squeeze);
		pix_item_t           it;
		logic [PIX_BITS-1:0] pix_set[$];
		frame_kind_t         kind;
		int                  r;
		int                  n_pix;
		int                  n_map;
		int unsigned         span;
		int unsigned         base;
		bit                  broken;
		bit                  skip_measure;

		r = $urandom_range(9, 0);
		kind = (r == 0) ? FRAME_NOISE : (r == 1) ? FRAME_FLAT :
			(r < 6) ? FRAME_NARROW : FRAME_WIDE;
		if (squeeze) kind = FRAME_NARROW;
		n_pix   = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
		gaps_on = ($urandom_range(3, 0) != 0);

		if (kind == FRAME_NOISE) begin
			repeat (n_pix) begin
				it.func  = 1'($urandom_range(1, 0));
				it.start = 1'($urandom_range(1, 0));
				it.pix   = PIX_BITS'($urandom());
				send_pixel(it);
			end
			return;
		end

		case (kind)
			FRAME_FLAT: span = 0;
			FRAME_WIDE: span = 65535;
			default: begin
				case ($urandom_range(2, 0))
					0: span = $urandom_range(16, 1);
					1: span = $urandom_range(4000, 17);
					default: span = $urandom_range(65535, 4001);
				endcase
			end
		endcase
		base = $urandom_range(65535 - span, 0);
		for (int i = 0; i < n_pix; i++)
			pix_set.push_back(PIX_BITS'($urandom_range(base + span, base)));

		broken       = ($urandom_range(7, 0) == 0);
		skip_measure = ($urandom_range(11, 0) == 0);
		if (!skip_measure) begin
			foreach (pix_set[i]) begin
				it.func  = FUNC_MEASURE;
				it.start = broken ? 1'($urandom_range(1, 0)) : (i == 0);
				it.pix   = pix_set[i];
				send_pixel(it);
			end
		end

		// receiver holds off while a long map pass piles up behind it
		if (squeeze) hold_asks <= hold_asks + 1;
		n_map = n_pix + (squeeze ? 40 : 0);
		repeat (n_map) begin
			it.func  = FUNC_MAP;
			it.start = 1'($urandom_range(1, 0));
			case ($urandom_range(5, 0))
				0: it.pix = PIX_BITS'($urandom());
				1: it.pix = $urandom_range(1, 0) ? PIX_BITS'(base) : PIX_BITS'(base + span);
				2: it.pix = $urandom_range(1, 0) ? PIX_BITS'(base + 1) : PIX_BITS'(base + span - 1);
				default: it.pix = pix_set[$urandom_range(n_pix - 1, 0)];
			endcase
			send_pixel(it);
		end
	endtask

	initial begin
		pix_item_t directed[];
		int frame_no;
		int target;

		directed = '{
			'{FUNC_MAP,     1'b0, 16'd0},     // unmeasured range after reset
			'{FUNC_MAP,     1'b1, 16'hFFFF},
			'{FUNC_MEASURE, 1'b1, 16'd500},
			'{FUNC_MAP,     1'b0, 16'd500},   // flat frame
			'{FUNC_MAP,     1'b0, 16'hFFFF},
			'{FUNC_MEASURE, 1'b1, 16'd0},
			'{FUNC_MEASURE, 1'b0, 16'hFFFF},
			'{FUNC_MAP,     1'b0, 16'd0},
			'{FUNC_MAP,     1'b0, 16'hFFFF},
			'{FUNC_MAP,     1'b0, 16'd1},
			'{FUNC_MAP,     1'b0, 16'hFFFE},
			'{FUNC_MAP,     1'b0, 16'h5555},
			'{FUNC_MAP,     1'b0, 16'hAAAA},
			'{FUNC_MEASURE, 1'b1, 16'd2000},
			'{FUNC_MEASURE, 1'b0, 16'd1000},
			'{FUNC_MEASURE, 1'b0, 16'd1500},
			'{FUNC_MAP,     1'b0, 16'd999},   // below the minimum
			'{FUNC_MAP,     1'b0, 16'd1000},
			'{FUNC_MAP,     1'b0, 16'd2000},
			'{FUNC_MAP,     1'b0, 16'd3000},  // above the maximum
			'{FUNC_MAP,     1'b1, 16'd1001},  // frame start ignored in map pass
			'{FUNC_MAP,     1'b0, 16'd1999},
			'{FUNC_MAP,     1'b0, 16'd1500},
			'{FUNC_MAP,     1'b0, 16'd1004}
		};
		stretch_chk        = new();
		items_sent         = 0;
		burst_left         = 0;
		gaps_on            = 1'b1;
		hold_asks          = 0;
		cycle_count        = 0;
		pix_in.valid       = 1'b0;
		pix_in.func        = FUNC_MEASURE;
		pix_in.frame_start = 1'b0;
		pix_in.pixel_value = '0;
		arst_n             = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_pixel(directed[i]);

		target   = items_sent + RANDOM_ITEMS;
		frame_no = 0;
		while (items_sent < target) begin
			run_frame(frame_no == 25 || frame_no == 140);
			frame_no++;
		end
		pix_in.valid <= 1'b0;

		while (stretch_chk.gray_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (stretch_chk.gray_due.size() != 0) begin
			$display("%0d gray values never arrived", stretch_chk.gray_due.size());
			stretch_chk.mismatches++;
		end
		if (stretch_chk.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
